// ----- src/wpc_pkg.sv -----
// Shared types, constants and the FNV-1a byte step for the window pattern classifier.
// No dependencies; imported by window_pattern_classifier.
`default_nettype none
package wpc_pkg;

   localparam logic [31:0] FNV_OFFSET = 32'h811C9DC5;
   localparam logic [31:0] FNV_PRIME  = 32'h01000193;
   localparam int          DIR_CAP    = 256;

   typedef logic [1:0] rule_type;
   localparam rule_type RULE_NONE  = 2'd0;
   localparam rule_type RULE_IDLE  = 2'd1;
   localparam rule_type RULE_LOOP  = 2'd2;
   localparam rule_type RULE_BURST = 2'd3;

   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_IDLE_MIN_LENGTH  = 3'd0;
   localparam csr_index_type CSR_IDLE_RANGE_LIMIT = 3'd1;
   localparam csr_index_type CSR_LOOP_MIN_REPEATS = 3'd2;
   localparam csr_index_type CSR_LOOP_MAX_PERIOD  = 3'd3;
   localparam csr_index_type CSR_BURST_SPAN       = 3'd4;
   localparam csr_index_type CSR_BURST_MIN_HITS   = 3'd5;
   localparam csr_index_type CSR_BURST_STEP_LIMIT = 3'd6;

   localparam logic [1:0] DIR_FLAT = 2'd0;
   localparam logic [1:0] DIR_UP   = 2'd1;
   localparam logic [1:0] DIR_DOWN = 2'd2;

   // one FNV-1a byte: xor, then multiply by the prime mod 2^32
   function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
      logic [31:0] x;
      x = h ^ {24'd0, b};
      return x * FNV_PRIME;
   endfunction

endpackage
`default_nettype wire

// ----- src/window_pattern_classifier.sv -----
// Sequence: n samples load at one item per cycle; the last item starts the range scan,
// then, as each test fails, the loop search (one direction code per cycle) and burst scan,
// then the hashing of the burst samples (or of the range for idle) and the emit state.
// Throughput: one item per cycle while loading; single-read-port sample and step memories set
// the classification time. Reset (synchronous) empties the window and loads register defaults.
`default_nettype none
// Top level: loads samples into a sample memory, derives step codes into a step memory,
// then runs idle, loop and burst tests in order. Uses wpc_pkg.
module window_pattern_classifier
   import wpc_pkg::*;
#(
   parameter int MAX_WINDOW = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [30:0] req_sample_value,
   input  wire logic [31:0] req_window_start,
   input  wire logic        req_last_sample,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_rule_kind,
   output logic [31:0]      rsp_span_first,
   output logic [31:0]      rsp_span_final,
   output logic [8:0]       rsp_hit_count,
   output logic [7:0]       rsp_loop_stride,
   output logic [31:0]      rsp_signature,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int NW = $clog2(MAX_WINDOW + 1);   // sample count
   localparam int AW = $clog2(MAX_WINDOW);       // memory address
   localparam int LW = ((NW > 9) ? NW : 9) + 2;  // index sums

   // sequencer codes
   localparam logic [4:0] S_LOAD      = 5'd0;
   localparam logic [4:0] S_START     = 5'd1;
   localparam logic [4:0] S_SCAN      = 5'd2;
   localparam logic [4:0] S_IDLE_CHK  = 5'd3;
   localparam logic [4:0] S_LOOP_INIT = 5'd4;
   localparam logic [4:0] S_LOOP_PER  = 5'd5;
   localparam logic [4:0] S_LOOP_RUN  = 5'd6;
   localparam logic [4:0] S_LOOP_NEXT = 5'd7;
   localparam logic [4:0] S_LOOP_DONE = 5'd8;
   localparam logic [4:0] S_BST_INIT  = 5'd9;
   localparam logic [4:0] S_BST_CHK   = 5'd10;
   localparam logic [4:0] S_BST_CNT   = 5'd11;
   localparam logic [4:0] S_BST_END   = 5'd12;
   localparam logic [4:0] S_BH_RD     = 5'd13;
   localparam logic [4:0] S_BH_LD     = 5'd14;
   localparam logic [4:0] S_HBYTE     = 5'd15;
   localparam logic [4:0] S_EMIT      = 5'd16;

   // configuration
   logic [8:0]  idle_min_ff;
   logic [31:0] idle_limit_ff;
   logic [7:0]  loop_min_rep_ff;
   logic [7:0]  loop_max_per_ff;
   logic [7:0]  burst_span_ff;
   logic [7:0]  burst_min_hits_ff;
   logic [30:0] burst_step_ff;

   // window bookkeeping
   logic [4:0]    state_ff, state_in;
   logic [NW-1:0] total_ff;
   logic [31:0]   base_ff;
   logic [NW-1:0] n_ff;

   // memories: samples, and per step {large, dir}
   logic [30:0] smem [MAX_WINDOW];
   logic [2:0]  amem [MAX_WINDOW];
   logic [30:0] srd_ff;
   logic [2:0]  ard_ff;
   logic [AW-1:0] s_addr, a_addr, a_waddr;
   logic [2:0]    a_wdata;
   logic          a_we;

   // scan
   logic [NW-1:0] sc_ff, ridx_ff;
   logic          rv_ff, issue;
   logic [30:0]   lo_ff, hi_ff, prev_ff;

   // loop search
   logic [NW-1:0] dl_ff, iss_off_ff, doff_ff;
   logic [7:0]    p_ff, ic_ff, dc_ff, rep_ff, bp_ff, br_ff;
   logic [31:0]   ph_ff, bh_ff;

   // burst search
   logic [NW-1:0] bi_ff, bs_ff, hk_ff;
   logic [7:0]    bj_ff, dj_ff, cnt_ff, bc_ff, he_ff;

   // hashing and result
   logic [31:0] hash_ff, hw_ff;
   logic [1:0]  byte_ff;
   rule_type    kind_ff;
   logic [31:0] rfirst_ff, rfin_ff;
   logic [8:0]  rcnt_ff;
   logic [7:0]  rstride_ff;

   logic        rsp_valid_ff;
   logic [1:0]  rsp_kind_ff;
   logic [31:0] rsp_first_ff, rsp_final_ff, rsp_sig_ff;
   logic [8:0]  rsp_cnt_ff;
   logic [7:0]  rsp_stride_ff;

   logic          in_acc;
   logic [NW-1:0] n_next;
   logic [NW-1:0] nm1;
   logic [30:0]   range_w, sdiff;
   logic [1:0]    sdir;
   logic          slarge;
   logic [31:0]   loop_base, loop_h, byte_h;
   logic          seg_end, seg_cont;
   logic [7:0]    c2;
   logic [15:0]   loop_prod;

   assign req_ready = (state_ff == S_LOAD);
   assign csr_ready = 1'b1;
   assign in_acc    = req_valid && req_ready;
   assign n_next    = (32'(total_ff) < 32'(MAX_WINDOW)) ? total_ff + 1'b1 : total_ff;
   assign nm1       = n_ff - 1'b1;
   assign range_w   = hi_ff - lo_ff;

   // step direction and size between the fresh sample and its predecessor
   assign sdiff  = (srd_ff > prev_ff) ? srd_ff - prev_ff : prev_ff - srd_ff;
   assign sdir   = (srd_ff > prev_ff) ? DIR_UP : ((srd_ff < prev_ff) ? DIR_DOWN : DIR_FLAT);
   assign slarge = (sdiff > burst_step_ff);

   // loop segment hashing on the data side
   assign loop_base = (dc_ff == 8'd0) ? FNV_OFFSET : hash_ff;
   assign loop_h    = fnv_step(loop_base, {6'd0, ard_ff[1:0]});
   assign seg_end   = rv_ff && (dc_ff == p_ff - 8'd1);
   assign seg_cont  = (LW'(doff_ff) + LW'({p_ff, 1'b0})) <= LW'(dl_ff);
   assign c2        = cnt_ff + {7'd0, ard_ff[2]};
   assign loop_prod = bp_ff * br_ff;
   assign byte_h    = fnv_step(hash_ff, 8'(hw_ff >> {byte_ff, 3'b000}));

   // read addresses and read issue
   always_comb begin
      s_addr  = AW'(total_ff);
      a_addr  = '0;
      issue   = 1'b0;
      a_we    = 1'b0;
      a_waddr = AW'(ridx_ff - 1'b1);
      a_wdata = {slarge, sdir};
      unique case (state_ff)
         S_SCAN: begin
            s_addr = AW'(sc_ff);
            issue  = (sc_ff < n_ff);
            a_we   = rv_ff && (ridx_ff != '0);
         end
         S_LOOP_RUN: begin
            a_addr = AW'(iss_off_ff + NW'(ic_ff));
            issue  = (LW'(iss_off_ff) + LW'(p_ff)) <= LW'(dl_ff);
         end
         S_BST_CNT: begin
            a_addr = AW'(LW'(bi_ff) - LW'(1) + LW'(bj_ff));
            issue  = (bj_ff < burst_span_ff);
         end
         S_BH_RD, S_BH_LD: s_addr = AW'(hk_ff);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (in_acc && (32'(total_ff) < 32'(MAX_WINDOW))) begin
         smem[AW'(total_ff)] <= req_sample_value;
      end
      srd_ff <= smem[s_addr];
   end

   always_ff @(posedge clock) begin
      if (a_we) begin
         amem[a_waddr] <= a_wdata;
      end
      ard_ff <= amem[a_addr];
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_min_ff       <= 9'd16;
         idle_limit_ff     <= 32'd100;
         loop_min_rep_ff   <= 8'd3;
         loop_max_per_ff   <= 8'd16;
         burst_span_ff     <= 8'd8;
         burst_min_hits_ff <= 8'd3;
         burst_step_ff     <= 31'd500;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_IDLE_MIN_LENGTH:  idle_min_ff       <= csr_wdata[8:0];
            CSR_IDLE_RANGE_LIMIT: idle_limit_ff     <= csr_wdata;
            CSR_LOOP_MIN_REPEATS: loop_min_rep_ff   <= csr_wdata[7:0];
            CSR_LOOP_MAX_PERIOD:  loop_max_per_ff   <= csr_wdata[7:0];
            CSR_BURST_SPAN:       burst_span_ff     <= csr_wdata[7:0];
            CSR_BURST_MIN_HITS:   burst_min_hits_ff <= csr_wdata[7:0];
            CSR_BURST_STEP_LIMIT: burst_step_ff     <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_LOAD:      if (in_acc && req_last_sample) state_in = S_START;
         S_START:     state_in = (32'(n_ff) < 32'd2) ? S_EMIT : S_SCAN;
         S_SCAN:      if (rv_ff && (ridx_ff == nm1)) state_in = S_IDLE_CHK;
         S_IDLE_CHK: begin
            if ((32'(n_ff) >= 32'(idle_min_ff)) && ({1'b0, range_w} < idle_limit_ff)) begin
               state_in = S_HBYTE;
            end else begin
               state_in = S_LOOP_INIT;
            end
         end
         S_LOOP_INIT: begin
            state_in = (32'(n_ff) < 32'({loop_min_rep_ff, 1'b0})) ? S_BST_INIT : S_LOOP_PER;
         end
         S_LOOP_PER: begin
            if ((p_ff <= loop_max_per_ff) && (32'(p_ff) <= 32'(dl_ff >> 1))) begin
               state_in = S_LOOP_RUN;
            end else begin
               state_in = S_LOOP_DONE;
            end
         end
         S_LOOP_RUN: begin
            if (seg_end && (!seg_cont || ((doff_ff != '0) && (loop_h != ph_ff)))) begin
               state_in = S_LOOP_NEXT;
            end
         end
         S_LOOP_NEXT: state_in = S_LOOP_PER;
         S_LOOP_DONE: state_in = (br_ff < loop_min_rep_ff) ? S_BST_INIT : S_EMIT;
         S_BST_INIT: begin
            state_in = (32'(n_ff) < 32'(burst_span_ff) + 32'd1) ? S_EMIT : S_BST_CHK;
         end
         S_BST_CHK: begin
            if ((LW'(bi_ff) + LW'(burst_span_ff)) > LW'(n_ff)) begin
               state_in = S_BST_END;
            end else if (burst_span_ff != 8'd0) begin
               state_in = S_BST_CNT;
            end
         end
         S_BST_CNT: if (rv_ff && (dj_ff == burst_span_ff - 8'd1)) state_in = S_BST_CHK;
         S_BST_END:   state_in = (bc_ff < burst_min_hits_ff) ? S_EMIT : S_BH_RD;
         S_BH_RD:     state_in = (he_ff == 8'd0) ? S_EMIT : S_BH_LD;
         S_BH_LD:     state_in = S_HBYTE;
         S_HBYTE: begin
            if (byte_ff == 2'd3) state_in = (kind_ff == RULE_IDLE) ? S_EMIT : S_BH_RD;
         end
         S_EMIT:      if (!rsp_valid_ff || rsp_ready) state_in = S_LOAD;
         default:     state_in = S_LOAD;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         total_ff     <= '0;
         rv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= issue;
         if (in_acc) begin
            total_ff <= req_last_sample ? '0 : n_next;
         end
         if ((state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (in_acc) begin
         if (total_ff == '0) base_ff <= req_window_start;
         if (req_last_sample) n_ff <= n_next;
      end
      unique case (state_ff)
         S_START: begin
            sc_ff      <= '0;
            kind_ff    <= RULE_NONE;
            rfirst_ff  <= '0;
            rfin_ff    <= '0;
            rcnt_ff    <= '0;
            rstride_ff <= '0;
            hash_ff    <= '0;
         end
         S_SCAN: begin
            if (issue) sc_ff <= sc_ff + 1'b1;
            ridx_ff <= sc_ff;
            if (rv_ff) begin
               prev_ff <= srd_ff;
               if (ridx_ff == '0) begin
                  lo_ff <= srd_ff;
                  hi_ff <= srd_ff;
               end else begin
                  if (srd_ff < lo_ff) lo_ff <= srd_ff;
                  if (srd_ff > hi_ff) hi_ff <= srd_ff;
               end
            end
         end
         S_IDLE_CHK: begin
            // idle verdict data; harmless when the test fails
            hash_ff    <= FNV_OFFSET;
            hw_ff      <= {1'b0, range_w};
            byte_ff    <= 2'd0;
            kind_ff    <= RULE_IDLE;
            rfin_ff    <= 32'(nm1);
            rcnt_ff    <= 9'(n_ff);
         end
         S_LOOP_INIT: begin
            kind_ff <= RULE_NONE;
            rfin_ff <= '0;
            rcnt_ff <= '0;
            hash_ff <= '0;
            dl_ff   <= (32'(nm1) > 32'(DIR_CAP)) ? NW'(DIR_CAP) : nm1;
            p_ff    <= 8'd2;
            bp_ff   <= 8'd0;
            br_ff   <= 8'd0;
            bh_ff   <= FNV_OFFSET;
         end
         S_LOOP_PER: begin
            iss_off_ff <= '0;
            ic_ff      <= 8'd0;
            dc_ff      <= 8'd0;
            doff_ff    <= '0;
         end
         S_LOOP_RUN: begin
            if (issue) begin
               if (ic_ff == p_ff - 8'd1) begin
                  ic_ff      <= 8'd0;
                  iss_off_ff <= iss_off_ff + NW'(p_ff);
               end else begin
                  ic_ff <= ic_ff + 8'd1;
               end
            end
            if (rv_ff) begin
               hash_ff <= loop_h;
               dc_ff   <= seg_end ? 8'd0 : dc_ff + 8'd1;
            end
            if (seg_end) begin
               doff_ff <= doff_ff + NW'(p_ff);
               if (doff_ff == '0) begin
                  ph_ff  <= loop_h;
                  rep_ff <= 8'd1;
               end else if (loop_h == ph_ff) begin
                  rep_ff <= rep_ff + 8'd1;
               end
            end
         end
         S_LOOP_NEXT: begin
            if ((rep_ff >= loop_min_rep_ff) && (rep_ff > br_ff)) begin
               bp_ff <= p_ff;
               br_ff <= rep_ff;
               bh_ff <= ph_ff;
            end
            p_ff <= p_ff + 8'd1;
         end
         S_LOOP_DONE: begin
            kind_ff    <= RULE_LOOP;
            rfirst_ff  <= '0;
            rfin_ff    <= (32'(loop_prod) > 32'(nm1)) ? 32'(nm1) : 32'(loop_prod);
            rcnt_ff    <= {1'b0, br_ff};
            rstride_ff <= bp_ff;
            hash_ff    <= bh_ff;
         end
         S_BST_INIT: begin
            kind_ff    <= RULE_NONE;
            rfirst_ff  <= '0;
            rfin_ff    <= '0;
            rcnt_ff    <= '0;
            rstride_ff <= '0;
            hash_ff    <= '0;
            bi_ff      <= NW'(1);
            bs_ff      <= '0;
            bc_ff      <= 8'd0;
         end
         S_BST_CHK: begin
            bj_ff  <= 8'd0;
            dj_ff  <= 8'd0;
            cnt_ff <= 8'd0;
            // zero span counts nothing, so no window can improve the best
            if (burst_span_ff == 8'd0) bi_ff <= bi_ff + 1'b1;
         end
         S_BST_CNT: begin
            if (issue) bj_ff <= bj_ff + 8'd1;
            if (rv_ff) begin
               if (dj_ff == burst_span_ff - 8'd1) begin
                  if ((c2 >= burst_min_hits_ff) && (c2 > bc_ff)) begin
                     bs_ff <= bi_ff;
                     bc_ff <= c2;
                  end
                  bi_ff <= bi_ff + 1'b1;
               end else begin
                  cnt_ff <= c2;
                  dj_ff  <= dj_ff + 8'd1;
               end
            end
         end
         S_BST_END: begin
            if (bc_ff >= burst_min_hits_ff) begin
               kind_ff   <= RULE_BURST;
               rfirst_ff <= 32'(bs_ff);
               rfin_ff   <= 32'(bs_ff) + 32'(burst_span_ff) - 32'd1;
               rcnt_ff   <= {1'b0, bc_ff};
               hash_ff   <= FNV_OFFSET;
            end
            hk_ff <= bs_ff;
            he_ff <= burst_span_ff;
         end
         S_BH_LD: begin
            hw_ff   <= {1'b0, srd_ff};
            byte_ff <= 2'd0;
            hk_ff   <= hk_ff + 1'b1;
            he_ff   <= he_ff - 8'd1;
         end
         S_HBYTE: begin
            hash_ff <= byte_h;
            byte_ff <= byte_ff + 2'd1;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_kind_ff   <= kind_ff;
               rsp_first_ff  <= (kind_ff == RULE_NONE) ? '0 : base_ff + rfirst_ff;
               rsp_final_ff  <= (kind_ff == RULE_NONE) ? '0 : base_ff + rfin_ff;
               rsp_cnt_ff    <= rcnt_ff;
               rsp_stride_ff <= rstride_ff;
               rsp_sig_ff    <= hash_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rule_kind   = rsp_kind_ff;
   assign rsp_span_first  = rsp_first_ff;
   assign rsp_span_final  = rsp_final_ff;
   assign rsp_hit_count   = rsp_cnt_ff;
   assign rsp_loop_stride = rsp_stride_ff;
   assign rsp_signature   = rsp_sig_ff;

`ifndef NO_ASSERTIONS
   a_total_cap: assert property (@(posedge clock) disable iff (reset)
      32'(total_ff) <= 32'(MAX_WINDOW))
      else $error("sample count beyond window size");
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_rule_kind == RULE_NONE) |->
         (rsp_signature == 32'd0) && (rsp_span_first == 32'd0) && (rsp_hit_count == 9'd0))
      else $error("empty verdict carries data");
   a_stride_loop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_rule_kind != RULE_LOOP) |-> (rsp_loop_stride == 8'd0))
      else $error("stride outside loop verdict");
   a_scan_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) && rv_ff |-> (ridx_ff < n_ff))
      else $error("scan read beyond window");
`endif

endmodule
`default_nettype wire

// ----- tb/window_pattern_classifier_test.sv -----
// Self-checking testbench for window_pattern_classifier: directed table, then random windows.
// Depends on wpc_pkg and window_pattern_classifier; checks results against a predictor or table.
`timescale 1ns / 1ps
module window_pattern_classifier_test;
   import wpc_pkg::*;

   localparam int WIN_CAP      = 256;
   localparam int RANDOM_ITEMS = 1800;
   localparam int PHASES       = 9;
   localparam int CYCLE_LIMIT  = 20_000_000;
   localparam int SETTLE       = 64;   // quiet cycles after the last result

   // one classification result, field for field
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] first;
      logic [31:0] last;
      logic [8:0]  count;
      logic [7:0]  stride;
      logic [31:0] sig;
   } verdict_type;

   // directed stimulus row: either a register write or one item
   typedef struct {
      bit            is_csr;
      csr_index_type idx;
      logic [31:0]   data;
      logic [30:0]   value;
      logic [31:0]   start;
      bit            mark;
      bit            typed;     // want holds the expected result as typed in
      verdict_type   want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [30:0] req_sample_value = '0;
   logic [31:0] req_window_start = '0;
   logic        req_last_sample = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_rule_kind;
   logic [31:0] rsp_span_first;
   logic [31:0] rsp_span_final;
   logic [8:0]  rsp_hit_count;
   logic [7:0]  rsp_loop_stride;
   logic [31:0] rsp_signature;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   window_pattern_classifier i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_sample_value(req_sample_value), .req_window_start(req_window_start),
      .req_last_sample(req_last_sample),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_rule_kind(rsp_rule_kind), .rsp_span_first(rsp_span_first),
      .rsp_span_final(rsp_span_final), .rsp_hit_count(rsp_hit_count),
      .rsp_loop_stride(rsp_loop_stride), .rsp_signature(rsp_signature),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor state
   logic [30:0] win_mem [WIN_CAP];
   logic [7:0]  dir_codes [WIN_CAP];
   int unsigned win_len;
   logic [31:0] win_base;

   logic [8:0]  cfg_idle_len;
   logic [31:0] cfg_idle_range;
   logic [7:0]  cfg_loop_reps;
   logic [7:0]  cfg_loop_period;
   logic [7:0]  cfg_burst_span;
   logic [7:0]  cfg_burst_hits;
   logic [30:0] cfg_burst_step;

   verdict_type pending_verdicts [$];

   int send_idle;      // percent of cycles the sender holds back
   int recv_idle;      // percent of cycles the receiver stalls
   int mismatches;
   int faults;         // unexpected results and leftovers
   int results_seen;
   int items_sent;
   int windows_sent;
   int rule_hits [4];
   int unsigned cycle_count;

   function automatic logic [31:0] fnv_mix(logic [31:0] h, logic [7:0] b);
      logic [31:0] x;
      x = h ^ {24'd0, b};
      return x * 32'h0100_0193;
   endfunction

   function automatic logic [31:0] fnv_mix_word(logic [31:0] h, logic [31:0] w);
      logic [31:0] acc;
      acc = h;
      for (int k = 0; k < 4; k++) acc = fnv_mix(acc, w[8*k +: 8]);
      return acc;
   endfunction

   function automatic logic [31:0] dir_segment_sig(int unsigned off, int unsigned p);
      logic [31:0] h;
      h = FNV_OFFSET;
      for (int unsigned i = 0; i < p; i++) h = fnv_mix(h, dir_codes[off + i]);
      return h;
   endfunction

   // classify the n held samples; priority idle, loop, burst
   function automatic verdict_type classify_window(int unsigned n);
      verdict_type v;
      logic [30:0] lo, hi, a, b, d;
      logic [31:0] range_w, ph, best_sig;
      int unsigned dl, rep, best_p, best_r, span_end, cnt, peak_start, best_cnt;
      int          e;
      bit          hit;
      v = '0;
      hit = 1'b0;
      if (n < 2) return v;

      // idle: small spread over the whole window
      if (n >= cfg_idle_len) begin
         lo = win_mem[0];
         hi = win_mem[0];
         for (int unsigned i = 1; i < n; i++) begin
            if (win_mem[i] < lo) lo = win_mem[i];
            if (win_mem[i] > hi) hi = win_mem[i];
         end
         range_w = {1'b0, hi} - {1'b0, lo};
         if (range_w < cfg_idle_range) begin
            v.kind = RULE_IDLE;
            v.first = win_base;
            v.last = win_base + 32'(n - 1);
            v.count = 9'(n);
            v.sig = fnv_mix_word(FNV_OFFSET, range_w);
            hit = 1'b1;
         end
      end

      // loop: best repeating period of direction codes
      if (!hit && n >= 2 * int'(cfg_loop_reps)) begin
         dl = 0;
         for (int unsigned i = 1; i < n && dl < WIN_CAP; i++) begin
            a = win_mem[i];
            b = win_mem[i-1];
            dir_codes[dl] = (a > b) ? 8'(DIR_UP) : (a < b) ? 8'(DIR_DOWN) : 8'(DIR_FLAT);
            dl++;
         end
         best_p = 0;
         best_r = 0;
         best_sig = FNV_OFFSET;
         for (int unsigned p = 2; p <= cfg_loop_period && p <= dl / 2; p++) begin
            ph = dir_segment_sig(0, p);
            rep = 1;
            for (int unsigned off = p; off + p <= dl; off += p) begin
               if (dir_segment_sig(off, p) != ph) break;
               rep++;
            end
            if (rep >= cfg_loop_reps && rep > best_r) begin
               best_p = p;
               best_r = rep;
               best_sig = ph;
            end
         end
         if (best_r >= cfg_loop_reps) begin
            span_end = best_p * best_r;
            if (span_end > n - 1) span_end = n - 1;
            v.kind = RULE_LOOP;
            v.first = win_base;
            v.last = win_base + 32'(span_end);
            v.count = 9'(best_r);
            v.stride = 8'(best_p);
            v.sig = best_sig;
            hit = 1'b1;
         end
      end

      // burst: sliding span with the most large steps
      if (!hit && n >= int'(cfg_burst_span) + 1) begin
         peak_start = 0;
         best_cnt = 0;
         for (int unsigned i = 1; i + cfg_burst_span <= n; i++) begin
            cnt = 0;
            for (int unsigned j = i; j < i + cfg_burst_span && j < n; j++) begin
               a = win_mem[j];
               b = win_mem[j-1];
               d = (a > b) ? a - b : b - a;
               if (d > cfg_burst_step) cnt++;
            end
            if (cnt >= cfg_burst_hits && cnt > best_cnt) begin
               peak_start = i;
               best_cnt = cnt;
            end
         end
         if (best_cnt >= cfg_burst_hits) begin
            e = int'(peak_start) + int'(cfg_burst_span) - 1;
            if (e > int'(n) - 1) e = int'(n) - 1;
            v.kind = RULE_BURST;
            v.first = win_base + 32'(peak_start);
            v.last = win_base + 32'(e);   // zero span wraps one below the start
            v.count = 9'(best_cnt);
            v.sig = FNV_OFFSET;
            for (int k = int'(peak_start); k <= e; k++)
               v.sig = fnv_mix_word(v.sig, {1'b0, win_mem[k]});
         end
      end
      return v;
   endfunction

   // ---------------------------------------------------------------- drivers
   // rsp_ready toggles at random per the current stall rate
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   // result checker: oldest expectation first
   always @(posedge clock) begin
      verdict_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_rule_kind, rsp_span_first, rsp_span_final, rsp_hit_count,
                 rsp_loop_stride, rsp_signature};
         results_seen++;
         if (pending_verdicts.size() == 0) begin
            faults++;
            $display("ERROR: result with nothing expected: kind %0d first %h sig %h",
                     got.kind, got.first, got.sig);
         end else begin
            want = pending_verdicts.pop_front();
            rule_hits[got.kind]++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"ERROR: result %0d mismatch\n",
                            "  expected kind %0d first %h last %h count %0d stride %0d sig %h\n",
                            "  actual   kind %0d first %h last %h count %0d stride %0d sig %h"},
                           results_seen, want.kind, want.first, want.last, want.count,
                           want.stride, want.sig, got.kind, got.first, got.last, got.count,
                           got.stride, got.sig);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ERROR: timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_verdicts.size());
         $display("window_pattern_classifier test failed");
         $finish;
      end
   end

   // send one item; on acceptance update the predictor and queue the expected result if marked last
   task automatic send_sample(logic [30:0] value, logic [31:0] start, bit mark,
                              bit typed = 1'b0, verdict_type want = '0);
      verdict_type v;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_value <= value;
      req_window_start <= start;
      req_last_sample <= mark;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (win_len == 0) win_base = start;
      if (win_len < WIN_CAP) begin
         win_mem[win_len] = value;
         win_len++;
      end
      if (mark) begin
         v = classify_window(win_len);
         win_len = 0;
         windows_sent++;
         pending_verdicts.push_back(typed ? want : v);
      end
   endtask

   // sender holds off until every expected result is back and the block is quiet
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_verdicts.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // one write, then csr_valid is dropped so back to back writes never collide on csr_valid
   task automatic write_reg(csr_index_type idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_IDLE_MIN_LENGTH:  cfg_idle_len = data[8:0];
         CSR_IDLE_RANGE_LIMIT: cfg_idle_range = data;
         CSR_LOOP_MIN_REPEATS: cfg_loop_reps = data[7:0];
         CSR_LOOP_MAX_PERIOD:  cfg_loop_period = data[7:0];
         CSR_BURST_SPAN:       cfg_burst_span = data[7:0];
         CSR_BURST_MIN_HITS:   cfg_burst_hits = data[7:0];
         CSR_BURST_STEP_LIMIT: cfg_burst_step = data[30:0];
         default: ;
      endcase
   endtask

   task automatic write_all(logic [31:0] il, logic [31:0] ir, logic [31:0] lr,
                            logic [31:0] lp, logic [31:0] bs, logic [31:0] bh,
                            logic [31:0] bl);
      write_reg(CSR_IDLE_MIN_LENGTH, il);
      write_reg(CSR_IDLE_RANGE_LIMIT, ir);
      write_reg(CSR_LOOP_MIN_REPEATS, lr);
      write_reg(CSR_LOOP_MAX_PERIOD, lp);
      write_reg(CSR_BURST_SPAN, bs);
      write_reg(CSR_BURST_MIN_HITS, bh);
      write_reg(CSR_BURST_STEP_LIMIT, bl);
   endtask

   // one random window; most are shaped so that a rule can fire
   task automatic send_window();
      logic [30:0] vals [$];
      logic [30:0] cur, pat [8];
      logic [31:0] start;
      int          len, style, p, spread, r;
      r = $urandom_range(59);
      if (r == 0) len = $urandom_range(200, 300);   // may fill and overflow the store
      else if (r < 3) len = 1;
      else len = $urandom_range(2, 24);
      style = $urandom_range(4);
      start = $urandom;
      cur = 31'($urandom);
      p = $urandom_range(2, 6);
      spread = ($urandom_range(2) == 0) ? 0 : ($urandom_range(1) ? 60 : 400);
      for (int k = 0; k < p; k++)
         pat[k] = 31'($urandom_range(2) * $urandom_range(1, 900));
      for (int i = 0; i < len; i++) begin
         case (style)
            0: vals.push_back(cur + 31'($urandom_range(0, spread)));          // quiet
            1: begin                                                           // periodic
               cur = (pat[i % p] == 0) ? cur : cur + pat[i % p] - 31'(450);
               vals.push_back(cur);
            end
            2: begin                                                           // jumpy
               if ($urandom_range(3) == 0) cur = cur + 31'($urandom_range(0, 4000)) - 31'(2000);
               vals.push_back(cur);
            end
            3: vals.push_back(31'($urandom));
            default: begin
               r = $urandom_range(2);
               vals.push_back(r == 0 ? 31'd0 : r == 1 ? 31'h7FFF_FFFF : 31'($urandom));
            end
         endcase
      end
      foreach (vals[i])
         send_sample(vals[i], (i == 0) ? start : 32'($urandom), i == len - 1);
   endtask

   // ---------------------------------------------------------------- directed table
   stim_row_type stim_rows [$];

   function automatic void add_item(logic [30:0] value, logic [31:0] start, bit mark,
                                    bit typed = 1'b0, verdict_type want = '0);
      stim_row_type row;
      row = '{default: '0};
      row.value = value;
      row.start = start;
      row.mark = mark;
      row.typed = typed;
      row.want = want;
      stim_rows.push_back(row);
   endfunction

   function automatic void add_reg(csr_index_type idx, logic [31:0] data);
      stim_row_type row;
      row = '{default: '0};
      row.is_csr = 1'b1;
      row.idx = idx;
      row.data = data;
      stim_rows.push_back(row);
   endfunction

   initial begin
      bit seen_csr;
      // reset defaults of the register file
      cfg_idle_len = 9'd16;
      cfg_idle_range = 32'd100;
      cfg_loop_reps = 8'd3;
      cfg_loop_period = 8'd16;
      cfg_burst_span = 8'd8;
      cfg_burst_hits = 8'd3;
      cfg_burst_step = 31'd500;
      win_len = 0;
      win_base = '0;
      send_idle = 0;
      recv_idle = 0;

      // single sample window: always an all-zero result
      add_item(31'd77, 32'd5, 1'b1, 1'b1, '0);
      // two flat samples under defaults: too short for any rule
      add_item(31'd0, 32'd9, 1'b0);
      add_item(31'd0, 32'd1, 1'b1, 1'b1, '0);
      // idle over the full sample range, start index wraps
      add_reg(CSR_IDLE_MIN_LENGTH, 32'd2);
      add_reg(CSR_IDLE_RANGE_LIMIT, 32'hFFFF_FFFF);
      add_item(31'd0, 32'hFFFF_FFFF, 1'b0);
      add_item(31'h7FFF_FFFF, 32'd0, 1'b1);
      // zero repeats: loop verdict with no period
      add_reg(CSR_IDLE_RANGE_LIMIT, 32'd0);
      add_reg(CSR_LOOP_MIN_REPEATS, 32'd0);
      add_item(31'd5, 32'h1234_5678, 1'b0);
      add_item(31'd5, 32'd0, 1'b1);
      // up/down alternation, period two
      add_reg(CSR_LOOP_MIN_REPEATS, 32'd2);
      add_reg(CSR_LOOP_MAX_PERIOD, 32'd2);
      add_item(31'd1, 32'd100, 1'b0);
      add_item(31'd9, 32'd0, 1'b0);
      add_item(31'd1, 32'd0, 1'b0);
      add_item(31'd9, 32'd0, 1'b0);
      add_item(31'd1, 32'd0, 1'b1);
      // zero-width burst span: end lands one below the start
      add_reg(CSR_LOOP_MIN_REPEATS, 32'd128);
      add_reg(CSR_BURST_SPAN, 32'd0);
      add_reg(CSR_BURST_MIN_HITS, 32'd0);
      add_item(31'd1, 32'd0, 1'b0);
      add_item(31'd2, 32'd0, 1'b1);
      // largest step limit: no step is large, nothing matches
      add_reg(CSR_BURST_SPAN, 32'd1);
      add_reg(CSR_BURST_MIN_HITS, 32'd1);
      add_reg(CSR_BURST_STEP_LIMIT, 32'h7FFF_FFFF);
      add_item(31'd0, 32'd40, 1'b0);
      add_item(31'h7FFF_FFFF, 32'd0, 1'b1, 1'b1, '0);
      // zero step limit: the single jump is a burst
      add_reg(CSR_BURST_STEP_LIMIT, 32'd0);
      add_item(31'd4, 32'hFFFF_FFFE, 1'b0);
      add_item(31'd4, 32'd0, 1'b0);
      add_item(31'h7FFF_FFFF, 32'd0, 1'b1);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part: register rows wait for the pipe to empty first
      seen_csr = 1'b0;
      foreach (stim_rows[i]) begin
         if (stim_rows[i].is_csr) begin
            if (!seen_csr) drain();
            seen_csr = 1'b1;
            write_reg(stim_rows[i].idx, stim_rows[i].data);
         end else begin
            seen_csr = 1'b0;
            send_sample(stim_rows[i].value, stim_rows[i].start, stim_rows[i].mark,
                        stim_rows[i].typed, stim_rows[i].want);
         end
      end

      // random part: three idling modes, three register settings in each
      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         case (ph)
            0: write_all(16, 100, 3, 16, 8, 3, 500);                        // reset values
            4: write_all(256, 32'hFFFF_FFFF, 128, 128, 255, 255, 32'h7FFF_FFFF);
            7: write_all(2, 0, 1, 2, 1, 1, 0);
            default: write_all($urandom_range(2, 24),
                               $urandom_range(1) ? $urandom_range(0, 500) : $urandom,
                               $urandom_range(1, 5), $urandom_range(2, 24),
                               $urandom_range(1, 10), $urandom_range(1, 4),
                               $urandom_range(1) ? $urandom_range(0, 1500)
                                                 : $urandom_range(0, 32'h7FFF_FFFF));
         endcase
         case (ph / 3)
            0: begin send_idle = 16; recv_idle = 75; end
            1: begin send_idle = 75; recv_idle = 16; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         while (items_sent < (ph + 1) * RANDOM_ITEMS / PHASES + stim_rows.size())
            send_window();
      end

      drain();
      faults += pending_verdicts.size();
      $display("Ran %0d items in %0d windows over %0d register settings; results: %0d none,",
               items_sent, windows_sent, PHASES + 1, rule_hits[RULE_NONE]);
      $display("  %0d idle, %0d loop, %0d burst; %0d mismatches, %0d stray results",
               rule_hits[RULE_IDLE], rule_hits[RULE_LOOP], rule_hits[RULE_BURST],
               mismatches, faults);
      if (mismatches == 0 && faults == 0)
         $display("window_pattern_classifier test passed");
      else
         $display("window_pattern_classifier test failed");
      $finish;
   end

endmodule

// ----- files.f -----
src/wpc_pkg.sv
src/window_pattern_classifier.sv
tb/window_pattern_classifier_test.sv
